// ----- rtl/core/lfl_pkg.sv -----
// ----------------------------------------------------------------------------
// lfl_pkg
// Shared types, register indexes and verdict codes of the login flood limiter.
// ----------------------------------------------------------------------------
package lfl_pkg;

  localparam int unsigned USER_COUNT_DEF = 4096;

  localparam int unsigned UID_W    = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STAMP_W  = 16;
  localparam int unsigned MINUTE_W = 27;
  localparam int unsigned HOUR_W   = 21;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned VERDICT_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_GAP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_MINUTE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_HOUR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MINUTE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_HOUR    = 3'd4;

  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_DELAY  = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_REJECT = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] reject_gap;
    logic [CFG_W-1:0] reject_minute;
    logic [CFG_W-1:0] reject_hour;
    logic [CFG_W-1:0] delay_minute;
    logic [CFG_W-1:0] delay_hour;
  } lfl_cfg_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour_win;
    logic [MINUTE_W-1:0] minute_win;
    logic [CNT_W-1:0]    hour_cnt;
    logic [CNT_W-1:0]    minute_cnt;
    logic [STAMP_W-1:0]  last_time;
  } lfl_entry_t;

  typedef struct packed {
    logic [MINUTE_W-1:0] minute;
    logic [HOUR_W-1:0]   hour;
    logic [STAMP_W-1:0]  cur_time;
  } lfl_event_t;

endpackage

// ----- rtl/core/lfl_table.sv -----
// ----------------------------------------------------------------------------
// lfl_table
// Single-port-write, single-port-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
module lfl_table #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/lfl_prep.sv -----
// ----------------------------------------------------------------------------
// lfl_prep
// Input stage: table index (user modulo table size) and minute/hour windows
// by reciprocal multiply, registered estimate, then one-step correction.
// ----------------------------------------------------------------------------
module lfl_prep #(
  parameter int unsigned USER_COUNT = lfl_pkg::USER_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  logic [lfl_pkg::UID_W-1:0]         user_id_i,
  input  logic [lfl_pkg::TIME_W-1:0]        now_seconds_i,
  output logic [$clog2(USER_COUNT)-1:0]     idx_o,
  output lfl_pkg::lfl_event_t               event_o
);

  import lfl_pkg::*;

  localparam int unsigned IdxW  = $clog2(USER_COUNT);
  localparam int unsigned UidRw = 24;
  localparam logic [35:0] UidRecip  = 36'(64'd16777216 / 64'(USER_COUNT));
  localparam logic [31:0] MinRecip  = 32'(64'd4294967296 / 64'd60);
  localparam logic [31:0] HourRecip = 32'(64'd4294967296 / 64'd3600);
  localparam logic [UID_W-1:0] UserLow = UID_W'(USER_COUNT);

  logic [UID_W-1:0]    uid_q;
  logic [TIME_W-1:0]   now_q;
  logic [UID_W-1:0]    uq_q;
  logic [MINUTE_W-1:0] mq_q;
  logic [HOUR_W-1:0]   hq_q;

  logic [35:0]         uid_prod;
  logic [63:0]         min_prod;
  logic [63:0]         hour_prod;

  logic [UID_W-1:0]    uid_rem;
  logic [31:0]         uid_rem_ext;
  logic [31:0]         uid_fix;
  logic [TIME_W-1:0]   min_rem;
  logic [TIME_W-1:0]   hour_rem;

  assign uid_prod  = 36'(user_id_i) * UidRecip;
  assign min_prod  = 64'(now_seconds_i) * 64'(MinRecip);
  assign hour_prod = 64'(now_seconds_i) * 64'(HourRecip);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      uid_q <= user_id_i;
      now_q <= now_seconds_i;
      uq_q  <= uid_prod[UidRw +: UID_W];
      mq_q  <= min_prod[32 +: MINUTE_W];
      hq_q  <= hour_prod[32 +: HOUR_W];
    end
  end

  assign uid_rem     = uid_q - UID_W'(uq_q * UserLow);
  assign uid_rem_ext = 32'(uid_rem);
  assign uid_fix     = (uid_rem_ext >= 32'(USER_COUNT)) ? uid_rem_ext - 32'(USER_COUNT)
                                                        : uid_rem_ext;
  assign idx_o       = uid_fix[IdxW-1:0];

  assign min_rem  = now_q - 32'(32'(mq_q) * 32'd60);
  assign hour_rem = now_q - 32'(32'(hq_q) * 32'd3600);

  assign event_o.minute   = (min_rem >= 32'd60) ? mq_q + MINUTE_W'(1) : mq_q;
  assign event_o.hour     = (hour_rem >= 32'd3600) ? hq_q + HOUR_W'(1) : hq_q;
  assign event_o.cur_time = now_q[STAMP_W-1:0];

endmodule

// ----- rtl/core/lfl_eval.sv -----
// ----------------------------------------------------------------------------
// lfl_eval
// Verdict and updated table entry for one login event and its stored entry.
// ----------------------------------------------------------------------------
module lfl_eval (
  input  lfl_pkg::lfl_cfg_t                cfg_i,
  input  lfl_pkg::lfl_event_t              event_i,
  input  lfl_pkg::lfl_entry_t              entry_i,
  output logic                             we_o,
  output lfl_pkg::lfl_entry_t              entry_o,
  output logic [lfl_pkg::VERDICT_W-1:0]    verdict_o
);

  import lfl_pkg::*;

  logic [STAMP_W-1:0] gap;
  logic [CNT_W-1:0]   mcnt;
  logic [CNT_W-1:0]   hcnt;
  logic [CNT_W-1:0]   mcnt_inc;
  logic [CNT_W-1:0]   hcnt_inc;
  logic               reject;
  logic               delay;

  always_comb begin
    gap = (entry_i.last_time >= event_i.cur_time) ? entry_i.last_time - event_i.cur_time
                                                  : event_i.cur_time - entry_i.last_time;
    mcnt = (entry_i.minute_win == event_i.minute) ? entry_i.minute_cnt : '0;
    hcnt = (entry_i.hour_win == event_i.hour) ? entry_i.hour_cnt : '0;
    mcnt_inc = (mcnt == '1) ? mcnt : mcnt + CNT_W'(1);
    hcnt_inc = (hcnt == '1) ? hcnt : hcnt + CNT_W'(1);
    reject = (gap <= STAMP_W'(cfg_i.reject_gap)) || (mcnt > cfg_i.reject_minute) ||
             (hcnt > cfg_i.reject_hour);
    delay  = (mcnt_inc > cfg_i.delay_minute) || (hcnt_inc > cfg_i.delay_hour);

    entry_o.hour_win   = event_i.hour;
    entry_o.minute_win = event_i.minute;
    entry_o.hour_cnt   = hcnt_inc;
    entry_o.minute_cnt = mcnt_inc;
    entry_o.last_time  = event_i.cur_time;
    we_o = !reject;

    priority if (reject) begin
      verdict_o = VERDICT_REJECT;
    end else if (delay) begin
      verdict_o = VERDICT_DELAY;
    end else begin
      verdict_o = VERDICT_ACCEPT;
    end
  end

endmodule

// ----- rtl/core/login_flood_limiter_unit.sv -----
// ----------------------------------------------------------------------------
// login_flood_limiter_unit
// Per-user login flood limiter: accept, delay or reject each login event.
// ----------------------------------------------------------------------------
// One table entry per user holds the last login time and the minute and hour
// counts with their window stamps, in a single memory with a registered read.
// Each event is a read-modify-write of its entry: a read state, then an
// evaluate state that writes back unless the event is rejected; a new event is
// taken as the previous one finishes, once the result register is free, and
// the result register lets the next event in while a verdict waits. After
// reset a clearing pass writes every entry once before the first event is
// taken; configuration writes are taken throughout.
module login_flood_limiter_unit #(
  parameter int unsigned USER_COUNT = lfl_pkg::USER_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lfl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lfl_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lfl_pkg::UID_W-1:0]        user_id_i,
  input  logic [lfl_pkg::TIME_W-1:0]       now_seconds_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lfl_pkg::VERDICT_W-1:0]    verdict_o
);

  import lfl_pkg::*;

  localparam int unsigned IdxW   = $clog2(USER_COUNT);
  localparam int unsigned EntryW = $bits(lfl_entry_t);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_EVAL  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [IdxW-1:0]      clr_cnt_q, clr_cnt_d;
  lfl_cfg_t             cfg_q;
  logic                 out_valid_q, out_valid_d;
  logic [VERDICT_W-1:0] verdict_q, verdict_d;

  logic                 in_xfer;
  logic                 out_free;
  logic                 finish;

  logic [IdxW-1:0]      idx;
  lfl_event_t           evt;

  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  logic [EntryW-1:0]    mem_wdata;
  logic                 mem_re;
  logic [EntryW-1:0]    mem_rdata;

  logic                 eval_we;
  lfl_entry_t           eval_entry;
  logic [VERDICT_W-1:0] eval_verdict;

  assign out_free   = !out_valid_q || out_ready_i;
  assign finish     = (state_q == ST_EVAL) && out_free;
  assign in_ready_o = (state_q == ST_IDLE) || finish;
  assign in_xfer    = in_valid_i && in_ready_o;

  lfl_prep #(
    .USER_COUNT(USER_COUNT)
  ) u_prep (
    .clk_i        (clk_i),
    .load_i       (in_xfer),
    .user_id_i    (user_id_i),
    .now_seconds_i(now_seconds_i),
    .idx_o        (idx),
    .event_o      (evt)
  );

  assign mem_re    = (state_q == ST_READ);
  assign mem_we    = (state_q == ST_CLEAR) || (finish && eval_we);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : idx;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : EntryW'(eval_entry);

  lfl_table #(
    .DEPTH(USER_COUNT),
    .WIDTH(EntryW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(idx),
    .rdata_o(mem_rdata)
  );

  lfl_eval u_eval (
    .cfg_i    (cfg_q),
    .event_i  (evt),
    .entry_i  (lfl_entry_t'(mem_rdata)),
    .we_o     (eval_we),
    .entry_o  (eval_entry),
    .verdict_o(eval_verdict)
  );

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    verdict_d   = verdict_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + IdxW'(1);
        if (clr_cnt_q == IdxW'(USER_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (finish) begin
          out_valid_d = 1'b1;
          verdict_d   = eval_verdict;
          state_d     = in_xfer ? ST_READ : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reject_gap    <= CFG_W'(3);
      cfg_q.reject_minute <= CFG_W'(30);
      cfg_q.reject_hour   <= CFG_W'(60);
      cfg_q.delay_minute  <= CFG_W'(5);
      cfg_q.delay_hour    <= CFG_W'(20);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REJECT_GAP:    cfg_q.reject_gap    <= cfg_wdata_i;
        CFG_REJECT_MINUTE: cfg_q.reject_minute <= cfg_wdata_i;
        CFG_REJECT_HOUR:   cfg_q.reject_hour   <= cfg_wdata_i;
        CFG_DELAY_MINUTE:  cfg_q.delay_minute  <= cfg_wdata_i;
        CFG_DELAY_HOUR:    cfg_q.delay_hour    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule
